### rtl/core/ecufs_pkg.sv
package ecufs_pkg;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic [1:0] CFG_SYNC_BYTE    = 2'd0;
	localparam logic [1:0] CFG_IDLE_LIMIT   = 2'd1;
	localparam logic [1:0] CFG_SPEED_WINDOW = 2'd2;

	localparam logic [7:0] SYNC_BYTE_RST    = 8'h01;
	localparam logic [7:0] IDLE_LIMIT_RST   = 8'd5;
	localparam logic [7:0] SPEED_WINDOW_RST = 8'd125;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic        frame_ok;
		logic [7:0]  rpm;
		logic [7:0]  engine_temp;
		logic [15:0] speed_total;
		logic        speed_latched;
		logic        timed_out;
	} out_t;

endpackage

### rtl/core/ecufs_out_buf.sv
module ecufs_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ecufs_pkg::out_t  push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output ecufs_pkg::out_t  out_data
);

	logic            out_v_q;
	logic            skid_v_q;
	ecufs_pkg::out_t out_q;
	ecufs_pkg::out_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !out_stall) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !out_stall) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held without an output entry");
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && skid_v_q))
		else $error("request pushed into a full buffer");
`endif

endmodule

### rtl/core/ecu_frame_sync_and_speed_sum_core.sv
// Frame sync and speed accumulator: each request is a received byte or a timer
// tick and yields exactly one result. The block takes one request per clock
// while in_stall is low; the frame window check, shift and counter
// updates are a single registered step, and a two-entry output buffer lets the
// input keep going while one result waits. in_stall rises only when both
// output entries are held. Configuration writes are always ready; indexes
// beyond speed_window are ignored.
module ecu_frame_sync_and_speed_sum_core #(
	parameter int FRAME_BYTES = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ecufs_pkg::in_t   in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output ecufs_pkg::out_t  out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [7:0]       cfg_data
);

	localparam int CW = $clog2(FRAME_BYTES + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(FRAME_BYTES);

	logic [7:0]    sync_q, idle_lim_q, speed_win_q;
	logic [7:0]    win_q [FRAME_BYTES];
	logic [7:0]    win_n [FRAME_BYTES];
	logic [CW-1:0] fill_q, fill_n;
	logic          hunt_q, hunt_n;
	logic [7:0]    idle_q, idle_n, idle_inc;
	logic [7:0]    wticks_q, wticks_n;
	logic [8:0]    wnext;
	logic [15:0]   sum_q, sum_n, hold_q, hold_n;
	logic [7:0]    rpm_q, rpm_n, temp_q, temp_n;
	logic [7:0]    chk;
	logic          accept;
	logic          buf_full;
	ecufs_pkg::out_t res;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = buf_full;
	assign cfg_ready = 1'b1;

	always_comb begin
		for (int i = 0; i < FRAME_BYTES; i++) begin
			win_n[i] = win_q[i];
		end
		fill_n   = fill_q;
		hunt_n   = hunt_q;
		idle_n   = idle_q;
		wticks_n = wticks_q;
		sum_n    = sum_q;
		hold_n   = hold_q;
		rpm_n    = rpm_q;
		temp_n   = temp_q;
		chk      = 8'd0;
		idle_inc = 8'd0;
		wnext    = 9'd0;
		res      = '0;
		if (in_data.req_type == ecufs_pkg::REQ_BYTE) begin
			idle_n = 8'd0;
			if (hunt_q) begin
				if (in_data.rx_byte == sync_q) begin
					win_n[0] = in_data.rx_byte;
					fill_n   = CW'(1);
					hunt_n   = 1'b0;
				end
			end else begin
				if (fill_q < FULL_CNT) begin
					for (int i = 0; i < FRAME_BYTES; i++) begin
						if (fill_q == CW'(i)) begin
							win_n[i] = in_data.rx_byte;
						end
					end
					fill_n = fill_q + CW'(1);
				end else begin
					for (int i = 0; i < FRAME_BYTES - 1; i++) begin
						win_n[i] = win_q[i+1];
					end
					win_n[FRAME_BYTES-1] = in_data.rx_byte;
				end
				for (int i = 1; i < FRAME_BYTES - 1; i++) begin
					chk = chk + win_n[i];
				end
				if (fill_n == FULL_CNT && win_n[0] == sync_q
						&& win_n[FRAME_BYTES-1] == chk) begin
					rpm_n        = win_n[1];
					temp_n       = win_n[4];
					sum_n        = sum_q + {8'd0, win_n[2]};
					hunt_n       = 1'b1;
					fill_n       = '0;
					res.frame_ok = 1'b1;
				end
			end
		end else begin
			idle_inc = (idle_q == 8'hff) ? idle_q : idle_q + 8'd1;
			idle_n   = idle_inc;
			if (idle_inc >= idle_lim_q) begin
				idle_n = 8'd0;
				if (!hunt_q) begin
					hunt_n        = 1'b1;
					fill_n        = '0;
					res.timed_out = 1'b1;
				end
			end
			wnext = {1'b0, wticks_q} + 9'd1;
			if (wnext > {1'b0, speed_win_q}) begin
				hold_n            = sum_q;
				sum_n             = 16'd0;
				wticks_n          = 8'd0;
				res.speed_latched = 1'b1;
			end else begin
				wticks_n = wnext[7:0];
			end
		end
		res.rpm         = rpm_n;
		res.engine_temp = temp_n;
		res.speed_total = hold_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q      <= ecufs_pkg::SYNC_BYTE_RST;
			idle_lim_q  <= ecufs_pkg::IDLE_LIMIT_RST;
			speed_win_q <= ecufs_pkg::SPEED_WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ecufs_pkg::CFG_SYNC_BYTE:    sync_q      <= cfg_data;
				ecufs_pkg::CFG_IDLE_LIMIT:   idle_lim_q  <= cfg_data;
				ecufs_pkg::CFG_SPEED_WINDOW: speed_win_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_BYTES; i++) begin
				win_q[i] <= 8'd0;
			end
			fill_q   <= '0;
			hunt_q   <= 1'b1;
			idle_q   <= 8'd0;
			wticks_q <= 8'd0;
			sum_q    <= 16'd0;
			hold_q   <= 16'd0;
			rpm_q    <= 8'd0;
			temp_q   <= 8'd0;
		end else if (accept) begin
			for (int i = 0; i < FRAME_BYTES; i++) begin
				win_q[i] <= win_n[i];
			end
			fill_q   <= fill_n;
			hunt_q   <= hunt_n;
			idle_q   <= idle_n;
			wticks_q <= wticks_n;
			sum_q    <= sum_n;
			hold_q   <= hold_n;
			rpm_q    <= rpm_n;
			temp_q   <= temp_n;
		end
	end

	ecufs_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef ASSERT_OFF
	a_hunt_empty: assert property (@(posedge clk) disable iff (!arst_n)
		hunt_q |-> (fill_q == '0))
		else $error("hunting with a partly filled window");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count beyond frame length");
	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.frame_ok |-> !res.speed_latched && !res.timed_out)
		else $error("byte and tick results mixed");
	a_frame_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.frame_ok |=> hunt_q)
		else $error("committed frame did not return to hunting");
`endif

endmodule
